/* hw/rtl/dfr_pkg.sv */
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// packet deframer. No dependencies; every other file of the block imports it.
package dfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [BYTE_W-1:0] HEADER_BYTE    = 8'h80;
  localparam logic [BYTE_W-1:0] DISCARD_MASK   = 8'hF0;
  localparam logic [BYTE_W-1:0] DISCARD_NIBBLE = 8'h50;
  localparam logic [CRC_W-1:0]  CRC_SEED       = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY       = 16'h1021;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RESET = 16'd260;

  // Register index, taken from paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_MAX_PAYLOAD = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_ONGOING    = 3'd0,
    ST_OK         = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_SIZE_ZERO  = 3'd3,
    ST_SIZE_BIG   = 3'd4,
    ST_CRC_BAD    = 3'd5,
    ST_DISCARD    = 3'd6
  } status_t;

  typedef struct packed {
    status_t           status;
    logic              payload_valid;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_index;
    logic [LEN_W-1:0]  packet_length;
  } result_t;

  // MSB-first CRC update over one byte: eight shift/xor steps.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/dfr_cfg.sv */
// APB configuration register of the deframer: holds max_payload_size.
// Depends on dfr_pkg.
module dfr_cfg
  import dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  max_payload_size
);

  logic              wr_en;
  logic [APB_AW-3:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_size <= MAX_PAYLOAD_RESET;
    end else if (wr_en && reg_idx == REG_MAX_PAYLOAD) begin
      max_payload_size <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MAX_PAYLOAD) begin
      prdata = {{(APB_DW-LEN_W){1'b0}}, max_payload_size};
    end
  end

endmodule

/* hw/rtl/dfr_frame.sv */
// Framing state machine: decodes header, length, payload and CRC bytes and
// forms one result per byte. Depends on dfr_pkg (types, crc_byte).
module dfr_frame
  import dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] data,
  input  logic [LEN_W-1:0]  max_payload_size,
  output result_t           res
);

  typedef enum logic [2:0] {
    PH_HDR,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [LEN_W-1:0]  idx, idx_next;
  logic [CRC_W-1:0]  crc, crc_next;
  logic [BYTE_W-1:0] crc_lo, crc_lo_next;
  logic [BYTE_W-1:0] first, first_next;
  logic [LEN_W-1:0]  full_len;
  logic              go_idle;

  assign full_len = {data, len[BYTE_W-1:0]};

  always_comb begin
    res         = '0;
    res.status  = ST_ONGOING;
    phase_next  = phase;
    len_next    = len;
    idx_next    = idx;
    crc_next    = crc;
    crc_lo_next = crc_lo;
    first_next  = first;
    go_idle     = 1'b0;

    unique case (phase)
      PH_HDR: begin
        if (data != HEADER_BYTE) begin
          res.status = ST_BAD_HEADER;
          go_idle    = 1'b1;
        end else begin
          phase_next = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        len_next   = {{(LEN_W-BYTE_W){1'b0}}, data};
        phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        res.packet_length = full_len;
        if (full_len == '0) begin
          res.status = ST_SIZE_ZERO;
          go_idle    = 1'b1;
        end else if (full_len > max_payload_size) begin
          res.status = ST_SIZE_BIG;
          go_idle    = 1'b1;
        end else begin
          len_next   = full_len;
          crc_next   = CRC_SEED;
          idx_next   = '0;
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.packet_length = len;
        res.payload_valid = 1'b1;
        res.payload_byte  = data;
        res.payload_index = idx;
        if (idx == '0) begin
          first_next = data;
        end
        crc_next = crc_byte(crc, data);
        if (idx == len - 16'd1) begin
          phase_next = PH_CRC_LO;
        end else begin
          idx_next = idx + 16'd1;
        end
      end
      PH_CRC_LO: begin
        res.packet_length = len;
        crc_lo_next       = data;
        phase_next        = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res.packet_length = len;
        if ({data, crc_lo} != crc) begin
          res.status = ST_CRC_BAD;
        end else if ((first & DISCARD_MASK) == DISCARD_NIBBLE) begin
          res.status = ST_DISCARD;
        end else begin
          res.status = ST_OK;
        end
        go_idle = 1'b1;
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR;
      len    <= '0;
      idx    <= '0;
      crc    <= CRC_SEED;
      crc_lo <= '0;
      first  <= '0;
    end else if (step) begin
      if (go_idle) begin
        phase  <= PH_HDR;
        len    <= '0;
        idx    <= '0;
        crc    <= CRC_SEED;
        crc_lo <= '0;
        first  <= '0;
      end else begin
        phase  <= phase_next;
        len    <= len_next;
        idx    <= idx_next;
        crc    <= crc_next;
        crc_lo <= crc_lo_next;
        first  <= first_next;
      end
    end
  end

endmodule

/* hw/rtl/crc_checked_packet_deframer.sv */
// Top level of the CRC-checked packet deframer: input register, framing
// logic, result register and APB register. Depends on dfr_pkg, dfr_cfg, dfr_frame.
//
// Received bytes enter on in_valid/in_ready, one item per byte; every byte
// yields exactly one result item on out_valid/out_ready. A packet is 0x80,
// a little-endian 16-bit payload length, the payload, and a little-endian
// CRC-16/CCITT-FALSE over the payload. Payload bytes come out as they
// arrive with payload_valid set and their index; the last result of a
// packet carries a non-zero status (ok, bad header, zero size, size too
// big, CRC bad, or discarded when the first payload byte's upper nibble is
// 0x5), after which the block waits for a new header. The block takes one
// item per clock cycle while the consumer keeps up. A byte lands in the input
// register when it is accepted, and its result is loaded into the result
// register when that register is empty or drains, which a stalled consumer
// can delay; out_valid is set from the result register. The framing decode
// and the eight-step CRC byte update sit between the input register and the
// result register as a single combinational pass. A stalled consumer holds
// the result register, which in turn holds the input register and drops
// in_ready.
// max_payload_size sits at APB address 0 and resets to 260.
module crc_checked_packet_deframer
  import dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STATUS_W-1:0] status,
  output logic              payload_valid,
  output logic [BYTE_W-1:0] payload_byte,
  output logic [LEN_W-1:0]  payload_index,
  output logic [LEN_W-1:0]  packet_length,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              advance;
  logic [LEN_W-1:0]  max_payload_size;
  result_t           res;
  result_t           out_res;

  // Move the held byte into the result register when that register is
  // empty or drains this cycle.
  assign advance  = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | advance;

  dfr_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .max_payload_size (max_payload_size)
  );

  dfr_frame u_frame (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .data             (s1_byte),
    .max_payload_size (max_payload_size),
    .res              (res)
  );

  // Input register: hold the accepted byte until the framing logic takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  // Result register: hold each result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign status        = out_res.status;
  assign payload_valid = out_res.payload_valid;
  assign payload_byte  = out_res.payload_byte;
  assign payload_index = out_res.payload_index;
  assign packet_length = out_res.packet_length;

  // A payload byte never ends a packet.
  a_payload_ongoing: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> status == ST_ONGOING)
    else $error("payload byte carries a final status");

  // Non-payload results carry zero byte and index.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> payload_byte == '0 && payload_index == '0)
    else $error("payload fields set without payload_valid");

  // A stalled input byte stays in the input register unchanged.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte))
    else $error("held input byte lost or changed");

endmodule
